>>> hdl/mpbm_pkg.sv
`default_nettype none
package mpbm_pkg;

  localparam int NODES      = 256;
  localparam int SYMBOLS    = 256;
  localparam int NODE_W     = $clog2(NODES);
  localparam int SYM_W      = $clog2(SYMBOLS);
  localparam int CNT_W      = NODE_W + 1;
  localparam int GOTO_AW    = NODE_W + SYM_W;

  localparam logic [2:0] MODE_INSERT  = 3'd0;
  localparam logic [2:0] MODE_END     = 3'd1;
  localparam logic [2:0] MODE_BUILD   = 3'd2;
  localparam logic [2:0] MODE_SCAN    = 3'd3;
  localparam logic [2:0] MODE_RESTART = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  symbol;
    logic [11:0] pattern_id;
    logic [7:0]  danger;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        match;
    logic [11:0] match_id;
    logic [7:0]  match_danger;
    logic [7:0]  scan_node;
  } result_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_INS_RD,
    OP_INS_WR,
    OP_END,
    OP_RESTART,
    OP_SC_RD,
    OP_SC_LOOK,
    OP_SC_OUT,
    OP_BR_RD,
    OP_BR_PR,
    OP_QH,
    OP_QF,
    OP_QU,
    OP_SRD,
    OP_SPR,
    OP_SCP
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       take;
    logic       emit;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic built;
    logic overflow;
    logic cursor_root;
    logic full;
    logic rd_zero;
    logic qempty;
    logic sym_last;
    logic copy_need;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> hdl/multi_pattern_byte_matcher.sv
`default_nettype none
// Channel  | Signals                       | Transfer
// item in  | start, busy, item_i           | edge with start high and busy low
// result   | done_o, result_o              | edge ending the cycle done_o is high
//
// End, restart and ignored items finish in idle; insert, scan and build step
// through states paced by registered store reads, build walking each root
// symbol, then each symbol of every queued node, with a copy step where a
// node inherits a pattern. After reset, busy stays high while the goto table
// is swept to zero. The result is shown for one cycle after the item finishes;
// the receiver cannot stall, and a new item may start then.
module multi_pattern_byte_matcher (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  mpbm_pkg::item_t    item_i,
  output logic               done_o,
  output mpbm_pkg::result_t  result_o
);

  mpbm_pkg::dp_cmd_t  cmd;
  mpbm_pkg::dp_stat_t stat;
  logic               ctrl_busy;

  mpbm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (item_i.mode),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (ctrl_busy),
    .done_o (done_o)
  );

  mpbm_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item_i),
    .stat_o   (stat),
    .result_o (result_o)
  );

  assign busy = ctrl_busy;

endmodule
`default_nettype wire

>>> hdl/mpbm_datapath.sv
`default_nettype none
module mpbm_datapath (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  mpbm_pkg::dp_cmd_t  cmd_i,
  input  mpbm_pkg::item_t    item_i,
  output mpbm_pkg::dp_stat_t stat_o,
  output mpbm_pkg::result_t  result_o
);

  localparam int NW = mpbm_pkg::NODE_W;
  localparam int SW = mpbm_pkg::SYM_W;
  localparam int CW = mpbm_pkg::CNT_W;
  localparam int AW = mpbm_pkg::GOTO_AW;

  logic [NW-1:0] goto_mem  [0:(1<<AW)-1];
  logic [NW-1:0] fail_mem  [0:mpbm_pkg::NODES-1];
  logic [NW-1:0] queue_mem [0:mpbm_pkg::NODES-1];
  logic [11:0]   tid_mem   [0:mpbm_pkg::NODES-1];
  logic [7:0]    tdg_mem   [0:mpbm_pkg::NODES-1];

  logic [NW-1:0] ga_q, gb_q, fail_rd_q, q_rd_q;
  logic [11:0]   tid_rd_q;
  logic [7:0]    tdg_rd_q;

  mpbm_pkg::item_t   item_q, item_d;
  mpbm_pkg::result_t res_q, res_d;
  logic [AW:0]       clr_q, clr_d;
  logic [CW-1:0]     node_cnt_q, node_cnt_d, head_q, head_d, tail_q, tail_d;
  logic [NW-1:0]     cursor_q, cursor_d, cur_q, cur_d, u_q, u_d, f_q, f_d, cpy_q, cpy_d;
  logic [SW-1:0]     s_q, s_d, sym_q;
  logic              built_q, built_d, ovf_q, ovf_d, hit_q, hit_d;
  logic [mpbm_pkg::NODES-1:0] tflag_q, tflag_d;

  logic          gw_en, fw_en, qw_en, tw_en;
  logic [AW-1:0] gw_addr, ra, rb;
  logic [NW-1:0] gw_data, fw_addr, fw_data, qw_addr, qw_data, tw_addr, tr_addr;
  logic [NW-1:0] fr_addr, qr_addr;
  logic [11:0]   tw_id;
  logic [7:0]    tw_dg;
  logic          v_nz, full, sym_last, copy_need, tail_room;

  assign sym_q     = item_q.symbol[SW-1:0];
  assign v_nz      = (ga_q != '0);
  assign full      = (node_cnt_q >= CW'(mpbm_pkg::NODES));
  assign sym_last  = (s_q == SW'(mpbm_pkg::SYMBOLS - 1));
  assign copy_need = v_nz && !tflag_q[ga_q] && tflag_q[gb_q];
  assign tail_room = (tail_q < CW'(mpbm_pkg::NODES));

  always_comb begin
    item_d     = item_q;
    clr_d      = clr_q;
    node_cnt_d = node_cnt_q;
    head_d     = head_q;
    tail_d     = tail_q;
    cursor_d   = cursor_q;
    cur_d      = cur_q;
    u_d        = u_q;
    f_d        = f_q;
    cpy_d      = cpy_q;
    s_d        = s_q;
    built_d    = built_q;
    ovf_d      = ovf_q;
    hit_d      = hit_q;
    tflag_d    = tflag_q;
    gw_en      = 1'b0;
    gw_addr    = {cursor_q, sym_q};
    gw_data    = '0;
    ra         = {cur_q, sym_q};
    rb         = {f_q, s_q};
    fw_en      = 1'b0;
    fw_addr    = ga_q;
    fw_data    = '0;
    qw_en      = 1'b0;
    qw_addr    = tail_q[NW-1:0];
    qw_data    = ga_q;
    tw_en      = 1'b0;
    tw_addr    = cursor_q;
    tw_id      = item_i.pattern_id;
    tw_dg      = item_i.danger;
    tr_addr    = ga_q;
    fr_addr    = q_rd_q;
    qr_addr    = head_q[NW-1:0];

    if (cmd_i.take) begin
      item_d = item_i;
      s_d    = '0;
      head_d = '0;
      tail_d = '0;
    end

    unique case (cmd_i.op)
      mpbm_pkg::OP_CLR: begin
        gw_en   = 1'b1;
        gw_addr = clr_q[AW-1:0];
        clr_d   = clr_q + 1'b1;
      end
      mpbm_pkg::OP_INS_RD: begin
        ra = {cursor_q, sym_q};
      end
      mpbm_pkg::OP_INS_WR: begin
        if (!v_nz) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            gw_en      = 1'b1;
            gw_data    = node_cnt_q[NW-1:0];
            cursor_d   = node_cnt_q[NW-1:0];
            node_cnt_d = node_cnt_q + 1'b1;
          end
        end else begin
          cursor_d = ga_q;
        end
      end
      mpbm_pkg::OP_END: begin
        tflag_d[cursor_q] = 1'b1;
        tw_en             = 1'b1;
        cursor_d          = '0;
      end
      mpbm_pkg::OP_RESTART: begin
        cur_d = '0;
      end
      mpbm_pkg::OP_SC_LOOK: begin
        cur_d = ga_q;
        hit_d = tflag_q[ga_q];
      end
      mpbm_pkg::OP_BR_RD: begin
        ra = {NW'(0), s_q};
      end
      mpbm_pkg::OP_BR_PR: begin
        if (v_nz) begin
          fw_en = 1'b1;
          if (tail_room) begin
            qw_en  = 1'b1;
            tail_d = tail_q + 1'b1;
          end
        end
        s_d = sym_last ? '0 : s_q + 1'b1;
      end
      mpbm_pkg::OP_QH: begin
        if (head_q == tail_q) begin
          built_d  = 1'b1;
          cur_d    = '0;
          cursor_d = '0;
        end
      end
      mpbm_pkg::OP_QF: begin
        u_d = q_rd_q;
      end
      mpbm_pkg::OP_QU: begin
        f_d    = fail_rd_q;
        head_d = head_q + 1'b1;
        s_d    = '0;
      end
      mpbm_pkg::OP_SRD: begin
        ra = {u_q, s_q};
      end
      mpbm_pkg::OP_SPR: begin
        if (v_nz) begin
          fw_en   = 1'b1;
          fw_data = gb_q;
          tr_addr = gb_q;
          if (tail_room) begin
            qw_en  = 1'b1;
            tail_d = tail_q + 1'b1;
          end
          if (copy_need) begin
            tflag_d[ga_q] = 1'b1;
            cpy_d         = ga_q;
          end else begin
            s_d = sym_last ? '0 : s_q + 1'b1;
          end
        end else begin
          // fill the missing edge from the failure node
          gw_en   = 1'b1;
          gw_addr = {u_q, s_q};
          gw_data = gb_q;
          s_d     = sym_last ? '0 : s_q + 1'b1;
        end
      end
      mpbm_pkg::OP_SCP: begin
        tw_en   = 1'b1;
        tw_addr = cpy_q;
        tw_id   = tid_rd_q;
        tw_dg   = tdg_rd_q;
        s_d     = sym_last ? '0 : s_q + 1'b1;
      end
      default: begin
      end
    endcase

    res_d.status       = cmd_i.status;
    res_d.match        = 1'b0;
    res_d.match_id     = '0;
    res_d.match_danger = '0;
    res_d.scan_node    = 8'(cur_d);
    if (cmd_i.op == mpbm_pkg::OP_SC_OUT && hit_q) begin
      res_d.match        = 1'b1;
      res_d.match_id     = tid_rd_q;
      res_d.match_danger = tdg_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (gw_en) goto_mem[gw_addr] <= gw_data;
    ga_q <= goto_mem[ra];
    gb_q <= goto_mem[rb];
  end

  always_ff @(posedge clk_i) begin
    if (fw_en) fail_mem[fw_addr] <= fw_data;
    fail_rd_q <= fail_mem[fr_addr];
  end

  always_ff @(posedge clk_i) begin
    if (qw_en) queue_mem[qw_addr] <= qw_data;
    q_rd_q <= queue_mem[qr_addr];
  end

  always_ff @(posedge clk_i) begin
    if (tw_en) begin
      tid_mem[tw_addr] <= tw_id;
      tdg_mem[tw_addr] <= tw_dg;
    end
    tid_rd_q <= tid_mem[tr_addr];
    tdg_rd_q <= tdg_mem[tr_addr];
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    u_q    <= u_d;
    f_q    <= f_d;
    cpy_q  <= cpy_d;
    s_q    <= s_d;
    head_q <= head_d;
    tail_q <= tail_d;
    hit_q  <= hit_d;
    if (cmd_i.emit) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      node_cnt_q <= CW'(1);
      cursor_q   <= '0;
      cur_q      <= '0;
      built_q    <= 1'b0;
      ovf_q      <= 1'b0;
      tflag_q    <= '0;
    end else begin
      clr_q      <= clr_d;
      node_cnt_q <= node_cnt_d;
      cursor_q   <= cursor_d;
      cur_q      <= cur_d;
      built_q    <= built_d;
      ovf_q      <= ovf_d;
      tflag_q    <= tflag_d;
    end
  end

  assign stat_o.clear_done  = clr_q[AW];
  assign stat_o.built       = built_q;
  assign stat_o.overflow    = ovf_q;
  assign stat_o.cursor_root = (cursor_q == '0);
  assign stat_o.full        = full;
  assign stat_o.rd_zero     = !v_nz;
  assign stat_o.qempty      = (head_q == tail_q);
  assign stat_o.sym_last    = sym_last;
  assign stat_o.copy_need   = copy_need;
  assign result_o           = res_q;

endmodule
`default_nettype wire

>>> hdl/mpbm_ctrl.sv
`default_nettype none
module mpbm_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  input  wire [2:0]          mode_i,
  input  mpbm_pkg::dp_stat_t stat_i,
  output mpbm_pkg::dp_cmd_t  cmd_o,
  output logic               busy,
  output logic               done_o
);

  typedef enum logic [15:0] {
    S_CLEAR   = 16'h0001,
    S_IDLE    = 16'h0002,
    S_INS_RD  = 16'h0004,
    S_INS_WR  = 16'h0008,
    S_SC_RD   = 16'h0010,
    S_SC_LOOK = 16'h0020,
    S_SC_OUT  = 16'h0040,
    S_BR_RD   = 16'h0080,
    S_BR_PR   = 16'h0100,
    S_QH      = 16'h0200,
    S_QF      = 16'h0400,
    S_QU      = 16'h0800,
    S_SRD     = 16'h1000,
    S_SPR     = 16'h2000,
    S_SCP     = 16'h4000,
    S_SPARE   = 16'h8000
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

  always_comb begin
    state_d      = state_q;
    cmd_o.op     = mpbm_pkg::OP_NONE;
    cmd_o.take   = 1'b0;
    cmd_o.emit   = 1'b0;
    cmd_o.status = mpbm_pkg::ST_OK;

    unique case (state_q)
      S_CLEAR: begin
        if (stat_i.clear_done) state_d = S_IDLE;
        else                   cmd_o.op = mpbm_pkg::OP_CLR;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.take = 1'b1;
          unique case (mode_i)
            mpbm_pkg::MODE_INSERT: begin
              if (stat_i.built) begin
                cmd_o.emit   = 1'b1;
                cmd_o.status = mpbm_pkg::ST_IGNORED;
              end else if (stat_i.overflow) begin
                cmd_o.emit   = 1'b1;
                cmd_o.status = mpbm_pkg::ST_FULL;
              end else begin
                state_d = S_INS_RD;
              end
            end
            mpbm_pkg::MODE_END: begin
              cmd_o.emit = 1'b1;
              if (stat_i.built || (!stat_i.overflow && stat_i.cursor_root)) begin
                cmd_o.status = mpbm_pkg::ST_IGNORED;
              end else if (stat_i.overflow) begin
                cmd_o.status = mpbm_pkg::ST_FULL;
              end else begin
                cmd_o.op = mpbm_pkg::OP_END;
              end
            end
            mpbm_pkg::MODE_BUILD: begin
              if (stat_i.built) begin
                cmd_o.emit   = 1'b1;
                cmd_o.status = mpbm_pkg::ST_IGNORED;
              end else begin
                state_d = S_BR_RD;
              end
            end
            mpbm_pkg::MODE_SCAN: begin
              if (!stat_i.built) begin
                cmd_o.emit   = 1'b1;
                cmd_o.status = mpbm_pkg::ST_IGNORED;
              end else begin
                state_d = S_SC_RD;
              end
            end
            mpbm_pkg::MODE_RESTART: begin
              cmd_o.emit = 1'b1;
              cmd_o.op   = mpbm_pkg::OP_RESTART;
            end
            default: begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = mpbm_pkg::ST_IGNORED;
            end
          endcase
        end
      end
      S_INS_RD: begin
        cmd_o.op = mpbm_pkg::OP_INS_RD;
        state_d  = S_INS_WR;
      end
      S_INS_WR: begin
        cmd_o.op   = mpbm_pkg::OP_INS_WR;
        cmd_o.emit = 1'b1;
        if (stat_i.rd_zero && stat_i.full) cmd_o.status = mpbm_pkg::ST_FULL;
        state_d = S_IDLE;
      end
      S_SC_RD: begin
        cmd_o.op = mpbm_pkg::OP_SC_RD;
        state_d  = S_SC_LOOK;
      end
      S_SC_LOOK: begin
        cmd_o.op = mpbm_pkg::OP_SC_LOOK;
        state_d  = S_SC_OUT;
      end
      S_SC_OUT: begin
        cmd_o.op   = mpbm_pkg::OP_SC_OUT;
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      S_BR_RD: begin
        cmd_o.op = mpbm_pkg::OP_BR_RD;
        state_d  = S_BR_PR;
      end
      S_BR_PR: begin
        cmd_o.op = mpbm_pkg::OP_BR_PR;
        state_d  = stat_i.sym_last ? S_QH : S_BR_RD;
      end
      S_QH: begin
        cmd_o.op = mpbm_pkg::OP_QH;
        if (stat_i.qempty) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end else begin
          state_d = S_QF;
        end
      end
      S_QF: begin
        cmd_o.op = mpbm_pkg::OP_QF;
        state_d  = S_QU;
      end
      S_QU: begin
        cmd_o.op = mpbm_pkg::OP_QU;
        state_d  = S_SRD;
      end
      S_SRD: begin
        cmd_o.op = mpbm_pkg::OP_SRD;
        state_d  = S_SPR;
      end
      S_SPR: begin
        cmd_o.op = mpbm_pkg::OP_SPR;
        if (stat_i.copy_need)     state_d = S_SCP;
        else if (stat_i.sym_last) state_d = S_QH;
        else                      state_d = S_SRD;
      end
      S_SCP: begin
        cmd_o.op = mpbm_pkg::OP_SCP;
        state_d  = stat_i.sym_last ? S_QH : S_SRD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.emit;
    end
  end

endmodule
`default_nettype wire
